/* design/lsac_pkg.sv */
`default_nettype none
package lsac_pkg;

    // access kinds
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_FETCH = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_SPLIT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WB        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WA        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_BITS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DSET_BITS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ISET_BITS = 3'd6;

    typedef struct packed {
        logic [31:0] address;
        logic [1:0]  mode;
    } req_t;

    typedef struct packed {
        logic       hit;
        logic       used_inst_cache;
        logic       replaced;
        logic       dirty_evicted;
        logic [6:0] fetch_words;
        logic [6:0] copy_back_words;
    } rsp_t;

    // configuration after saturation
    typedef struct packed {
        logic       split;
        logic       wb;
        logic       wa;
        logic [3:0] off;
        logic [4:0] ways;
        logic [4:0] dsb;
        logic [4:0] isb;
    } cfg_t;

    // classification of one request
    typedef struct packed {
        logic       inst;
        logic       write;
        logic       nop;
        logic [6:0] words;
    } flags_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EXEC
    } back_state_t;

    typedef struct packed {
        logic clearing;
        logic take;
        logic done;
    } back_stat_t;

endpackage
`default_nettype wire

/* design/lsac_queue.sv */
`default_nettype none
module lsac_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic                  empty,
    output logic      [WIDTH-1:0] rdata
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end
endmodule
`default_nettype wire

/* design/lsac_front.sv */
`default_nettype none
module lsac_front #(
    parameter int MAX_SET_BITS = 10,
    parameter int ADDR_BITS    = 32,
    parameter int SET_W        = 10,
    parameter int TAG_W        = 30
) (
    input  wire lsac_pkg::req_t   req,
    input  wire lsac_pkg::cfg_t   cfg,
    output logic [SET_W-1:0]      set_idx,
    output logic [TAG_W-1:0]      tag,
    output lsac_pkg::flags_t      flags
);
    import lsac_pkg::*;

    logic [ADDR_BITS-1:0] a_ext;
    logic [ADDR_BITS-1:0] shifted;
    logic [ADDR_BITS-1:0] tag_full;
    logic [4:0]           sb;
    logic [SET_W-1:0]     mask;

    always_comb
    begin
        for (int i = 0; i < ADDR_BITS; i++)
        begin
            a_ext[i] = (i < 32) ? req.address[i % 32] : 1'b0;
        end
        flags.inst  = cfg.split && (req.mode == MODE_FETCH);
        flags.write = (req.mode == MODE_WRITE);
        flags.nop   = (req.mode == MODE_NONE);
        flags.words = 7'd1 << (cfg.off - 4'd2);
        sb = flags.inst ? cfg.isb : cfg.dsb;
        if (sb > 5'(MAX_SET_BITS))
        begin
            sb = 5'(MAX_SET_BITS);
        end
        mask     = ~({SET_W{1'b1}} << sb);
        shifted  = a_ext >> cfg.off;
        set_idx  = shifted[SET_W-1:0] & mask;
        tag_full = a_ext >> (6'(cfg.off) + 6'(sb));
        tag      = tag_full[TAG_W-1:0];
    end
endmodule
`default_nettype wire

/* design/lsac_back.sv */
`default_nettype none
module lsac_back #(
    parameter int MAX_WAYS = 8,
    parameter int SET_W    = 10,
    parameter int TAG_W    = 30,
    parameter int RANK_W   = 3,
    parameter int QW       = 50
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire lsac_pkg::cfg_t  cfg,
    input  wire logic            q_empty,
    input  wire logic [QW-1:0]   q_data,
    output logic                 q_pop,
    input  wire logic            res_full,
    output logic                 res_push,
    output lsac_pkg::rsp_t       rsp,
    output lsac_pkg::back_stat_t stat
);
    import lsac_pkg::*;

    localparam int SETS  = 1 << SET_W;
    localparam int WAY_W = RANK_W;
    localparam int FLG_W = $bits(flags_t);
    localparam logic [RANK_W-1:0] RANK_TOP = RANK_W'(MAX_WAYS - 1);

    typedef logic [MAX_WAYS-1:0][TAG_W-1:0] tag_row_t;
    typedef struct packed {
        logic [MAX_WAYS-1:0]             valid;
        logic [MAX_WAYS-1:0]             dirty;
        logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
    } dmeta_t;
    typedef struct packed {
        logic [MAX_WAYS-1:0]             valid;
        logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
    } imeta_t;

    tag_row_t dtag_mem [SETS];
    tag_row_t itag_mem [SETS];
    dmeta_t   dmeta_mem [SETS];
    imeta_t   imeta_mem [SETS];

    tag_row_t dtag_rd_reg, itag_rd_reg;
    dmeta_t   dmeta_rd_reg;
    imeta_t   imeta_rd_reg;

    back_state_t state_reg, state_next;
    logic [SET_W-1:0] clr_reg, clr_next;
    logic [QW-1:0]    cur_reg;

    logic [SET_W-1:0] cur_set;
    logic [TAG_W-1:0] cur_tag;
    flags_t           fl;

    tag_row_t                        tags, tags_new;
    logic [MAX_WAYS-1:0]             valid, dirty, valid_new, dirty_new, in_use;
    logic [MAX_WAYS-1:0][RANK_W-1:0] rank, rank_new;
    logic             hit, free_found, fill, repl, dev, update, fresh;
    logic [WAY_W-1:0] hw, fw, vw, w;
    logic [RANK_W-1:0] r;
    logic [6:0]       copy;
    logic             rd_en, dtag_we, itag_we, dmeta_we, imeta_we;
    logic [SET_W-1:0] wr_addr;
    dmeta_t           dmeta_wd;
    imeta_t           imeta_wd;

    assign cur_set = cur_reg[QW-1 -: SET_W];
    assign cur_tag = cur_reg[FLG_W +: TAG_W];
    assign fl      = flags_t'(cur_reg[FLG_W-1:0]);

    // lookup, victim choice and LRU update on the registered set row
    always_comb
    begin
        tags  = fl.inst ? itag_rd_reg : dtag_rd_reg;
        valid = fl.inst ? imeta_rd_reg.valid : dmeta_rd_reg.valid;
        rank  = fl.inst ? imeta_rd_reg.rank : dmeta_rd_reg.rank;
        dirty = fl.inst ? '0 : dmeta_rd_reg.dirty;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            in_use[i] = (5'(i) < cfg.ways);
        end
        hit = 1'b0;
        hw  = '0;
        free_found = 1'b0;
        fw  = '0;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (!hit && in_use[i] && valid[i] && tags[i] == cur_tag)
            begin
                hit = 1'b1;
                hw  = WAY_W'(i);
            end
            if (!free_found && in_use[i] && !valid[i])
            begin
                free_found = 1'b1;
                fw = WAY_W'(i);
            end
        end
        vw = '0;
        for (int i = 1; i < MAX_WAYS; i++)
        begin
            if (in_use[i] && rank[i] > rank[vw])
            begin
                vw = WAY_W'(i);
            end
        end
        fill   = !fl.nop && !hit && !(fl.write && !cfg.wa);
        repl   = fill && !free_found;
        fresh  = fill && free_found;
        dev    = repl && dirty[vw];
        update = !fl.nop && (hit || fill);
        w      = hit ? hw : (free_found ? fw : vw);
        r      = rank[w];

        copy = (fl.write && !cfg.wb) ? 7'd1 : 7'd0;
        if (!fl.nop && !hit && fl.write && !cfg.wa && cfg.wb)
        begin
            copy = 7'd1;
        end
        if (dev)
        begin
            copy = copy + fl.words;
        end

        rank_new = rank;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (WAY_W'(i) != w && in_use[i] && valid[i] && (fresh || rank[i] < r)
                && rank[i] < RANK_TOP)
            begin
                rank_new[i] = rank[i] + 1'b1;
            end
        end
        rank_new[w] = '0;
        valid_new = valid;
        dirty_new = dirty;
        tags_new  = tags;
        if (fill)
        begin
            valid_new[w] = 1'b1;
            dirty_new[w] = fl.write && cfg.wb;
            tags_new[w]  = cur_tag;
        end
        else if (hit && fl.write && cfg.wb)
        begin
            dirty_new[w] = 1'b1;
        end

        rsp.hit             = hit && !fl.nop;
        rsp.used_inst_cache = fl.inst && !fl.nop;
        rsp.replaced        = repl;
        rsp.dirty_evicted   = dev;
        rsp.fetch_words     = fill ? fl.words : 7'd0;
        rsp.copy_back_words = copy;
    end

    // sequencer: clear pass, then read row / update row per request
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        q_pop      = 1'b0;
        res_push   = 1'b0;
        rd_en      = 1'b0;
        dtag_we    = 1'b0;
        itag_we    = 1'b0;
        dmeta_we   = 1'b0;
        imeta_we   = 1'b0;
        wr_addr    = cur_set;
        dmeta_wd   = '{valid: valid_new, dirty: dirty_new, rank: rank_new};
        imeta_wd   = '{valid: valid_new, rank: rank_new};
        case (state_reg)
            BK_CLEAR:
            begin
                wr_addr  = clr_reg;
                dmeta_wd = '0;
                imeta_wd = '0;
                dmeta_we = 1'b1;
                imeta_we = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == {SET_W{1'b1}})
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (!q_empty && !res_full)
                begin
                    q_pop      = 1'b1;
                    rd_en      = 1'b1;
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                res_push   = 1'b1;
                dtag_we    = fill && !fl.inst;
                itag_we    = fill && fl.inst;
                dmeta_we   = update && !fl.inst;
                imeta_we   = update && fl.inst;
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_CLEAR;
            end
        endcase
    end

    assign stat.clearing = (state_reg == BK_CLEAR);
    assign stat.take     = q_pop;
    assign stat.done     = res_push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            dtag_rd_reg  <= dtag_mem[q_data[QW-1 -: SET_W]];
            itag_rd_reg  <= itag_mem[q_data[QW-1 -: SET_W]];
            dmeta_rd_reg <= dmeta_mem[q_data[QW-1 -: SET_W]];
            imeta_rd_reg <= imeta_mem[q_data[QW-1 -: SET_W]];
        end
        if (dtag_we)
        begin
            dtag_mem[wr_addr] <= tags_new;
        end
        if (itag_we)
        begin
            itag_mem[wr_addr] <= tags_new;
        end
        if (dmeta_we)
        begin
            dmeta_mem[wr_addr] <= dmeta_wd;
        end
        if (imeta_we)
        begin
            imeta_mem[wr_addr] <= imeta_wd;
        end
    end
endmodule
`default_nettype wire

/* design/lru_set_assoc_cache_model.sv */
`default_nettype none
// Channel   Ports                          Request accepted when
// ------    -----------------------------  ---------------------------
// input     req, push, full                push high, full low
// result    rsp, empty, pop                pop high, empty low
// config    cfg_we, cfg_idx, cfg_data      cfg_we high
//
// In the back end, BK_IDLE takes a request and reads its set row (tags,
// valid, dirty, LRU ranks); BK_EXEC updates it and writes it back.
// After reset a clearing pass zeroes the valid/dirty/rank rows of every set,
// one set per cycle; full stays high meanwhile. A two-entry queue decouples
// front from back, and a two-entry result queue lets requests arrive while
// results wait on pop.
module lru_set_assoc_cache_model #(
    parameter int MAX_WAYS     = 8,
    parameter int MAX_SET_BITS = 10,
    parameter int ADDR_BITS    = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire lsac_pkg::req_t                 req,
    input  wire logic                           push,
    output logic                                full,
    output lsac_pkg::rsp_t                      rsp,
    output logic                                empty,
    input  wire logic                           pop,
    input  wire logic                           cfg_we,
    input  wire logic [lsac_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [lsac_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lsac_pkg::*;

    localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int TAG_W  = ADDR_BITS - 2;
    localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int QW     = SET_W + TAG_W + $bits(flags_t);
    localparam int RW     = $bits(rsp_t);

    // configuration registers, raw as written
    logic       split_reg, wb_reg, wa_reg;
    logic [3:0] off_reg, ways_reg, dsb_reg, isb_reg;
    cfg_t       cfg;

    logic [SET_W-1:0] f_set;
    logic [TAG_W-1:0] f_tag;
    flags_t           f_flags;
    logic             q_full, q_empty, q_pop, res_full, res_push;
    logic [QW-1:0]    q_data;
    rsp_t             b_rsp;
    logic [RW-1:0]    res_data;
    back_stat_t       stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            split_reg <= 1'b0;
            wb_reg    <= 1'b1;
            wa_reg    <= 1'b1;
            off_reg   <= 4'd4;
            ways_reg  <= 4'd1;
            dsb_reg   <= 4'd6;
            isb_reg   <= 4'd6;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_SPLIT:     split_reg <= cfg_data[0];
                REG_WB:        wb_reg    <= cfg_data[0];
                REG_WA:        wa_reg    <= cfg_data[0];
                REG_OFF_BITS:  off_reg   <= cfg_data;
                REG_WAYS:      ways_reg  <= cfg_data;
                REG_DSET_BITS: dsb_reg   <= cfg_data;
                REG_ISET_BITS: isb_reg   <= cfg_data;
                default:       ;
            endcase
        end
    end

    // saturate the geometry into its legal range
    always_comb
    begin
        cfg.split = split_reg;
        cfg.wb    = wb_reg;
        cfg.wa    = wa_reg;
        cfg.off   = (off_reg < 4'd2) ? 4'd2 : ((off_reg > 4'd8) ? 4'd8 : off_reg);
        if (ways_reg == 4'd0)
        begin
            cfg.ways = 5'd1;
        end
        else if (5'(ways_reg) > 5'(MAX_WAYS))
        begin
            cfg.ways = 5'(MAX_WAYS);
        end
        else
        begin
            cfg.ways = 5'(ways_reg);
        end
        cfg.dsb = (5'(dsb_reg) > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS) : 5'(dsb_reg);
        cfg.isb = (5'(isb_reg) > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS) : 5'(isb_reg);
    end

    // hold requests off while the clearing pass runs
    assign full = q_full || stat.clearing;

    lsac_front #(
        .MAX_SET_BITS(MAX_SET_BITS),
        .ADDR_BITS   (ADDR_BITS),
        .SET_W       (SET_W),
        .TAG_W       (TAG_W)
    ) u_front (
        .req    (req),
        .cfg    (cfg),
        .set_idx(f_set),
        .tag    (f_tag),
        .flags  (f_flags)
    );

    lsac_queue #(.WIDTH(QW), .DEPTH(2)) u_req_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push && !full),
        .full (q_full),
        .wdata({f_set, f_tag, f_flags}),
        .pop  (q_pop),
        .empty(q_empty),
        .rdata(q_data)
    );

    lsac_back #(
        .MAX_WAYS(MAX_WAYS),
        .SET_W   (SET_W),
        .TAG_W   (TAG_W),
        .RANK_W  (RANK_W),
        .QW      (QW)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_empty (q_empty),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .res_full(res_full),
        .res_push(res_push),
        .rsp     (b_rsp),
        .stat    (stat)
    );

    lsac_queue #(.WIDTH(RW), .DEPTH(2)) u_res_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (res_push),
        .full (res_full),
        .wdata(b_rsp),
        .pop  (pop),
        .empty(empty),
        .rdata(res_data)
    );

    assign rsp = rsp_t'(res_data);

    // no request leaves the queue during the clearing pass
    a_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n)
        stat.clearing |-> !q_pop)
        else $error("request taken during clearing pass");

    // every request taken yields its result on the next cycle
    a_take_done: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> res_push)
        else $error("result not produced after take");

    // a result is never pushed into a full result queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result queue overflow");

    // back end never takes two requests in a row
    a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> !q_pop)
        else $error("back end overlapped two requests");

endmodule
`default_nettype wire

/* tb/tb_lru_set_assoc_cache_model.sv */
`default_nettype none
module tb_lru_set_assoc_cache_model;
    import lsac_pkg::*;

    localparam int NWAYS     = 8;
    localparam int NSETBITS  = 10;
    localparam int NLINES    = NWAYS << NSETBITS;
    localparam int RANK_TOP  = NWAYS - 1;
    localparam int N_RANDOM  = 900;
    localparam int CYCLE_CAP = 400000;

    logic clk;
    logic rst_n;
    req_t req;
    logic push;
    logic full;
    rsp_t rsp;
    logic empty;
    logic pop;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    lru_set_assoc_cache_model u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .push     (push),
        .full     (full),
        .rsp      (rsp),
        .empty    (empty),
        .pop      (pop),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    // clock: 4 high, 4 low
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // shadow of the configuration registers, raw values as written
    logic [3:0] sh_cfg [0:6];

    // shadow cache state; unified and data cache share the data arrays
    logic [29:0] d_tag  [0:NLINES-1];
    logic        d_vld  [0:NLINES-1];
    logic        d_drt  [0:NLINES-1];
    int          d_rank [0:NLINES-1];
    logic [29:0] i_tag  [0:NLINES-1];
    logic        i_vld  [0:NLINES-1];
    int          i_rank [0:NLINES-1];

    rsp_t expected_rsp [$];
    int   errors;
    int   cycles;

    // move way w of a set to most recent; fresh when w was invalid before
    task automatic promote(input bit inst, input int base, input int ways,
                           input int w, input bit fresh);
        int r;
        int rk;
        bit v;
        r = inst ? i_rank[base+w] : d_rank[base+w];
        for (int i = 0; i < ways; i++)
        begin
            v  = inst ? i_vld[base+i] : d_vld[base+i];
            rk = inst ? i_rank[base+i] : d_rank[base+i];
            if (i != w && v && (fresh || rk < r) && rk < RANK_TOP)
            begin
                if (inst)
                    i_rank[base+i] = rk + 1;
                else
                    d_rank[base+i] = rk + 1;
            end
        end
        if (inst)
            i_rank[base+w] = 0;
        else
            d_rank[base+w] = 0;
    endtask

    // work out the outcome of one access and update the shadow cache
    task automatic predict_access(input req_t rq, output rsp_t res);
        bit inst, wr, hit, found, wbk, wal, v;
        int off, ways, sb, words, set, base, w;
        logic [29:0] tag, tg;
        res = '0;
        if (rq.mode == MODE_NONE)
            return;
        wbk   = sh_cfg[REG_WB][0];
        wal   = sh_cfg[REG_WA][0];
        inst  = sh_cfg[REG_SPLIT][0] && rq.mode == MODE_FETCH;
        wr    = rq.mode == MODE_WRITE;
        off   = sh_cfg[REG_OFF_BITS] < 2 ? 2 : (sh_cfg[REG_OFF_BITS] > 8 ? 8
                : sh_cfg[REG_OFF_BITS]);
        ways  = sh_cfg[REG_WAYS] < 1 ? 1 : (sh_cfg[REG_WAYS] > NWAYS ? NWAYS
                : sh_cfg[REG_WAYS]);
        sb    = inst ? sh_cfg[REG_ISET_BITS] : sh_cfg[REG_DSET_BITS];
        if (sb > NSETBITS)
            sb = NSETBITS;
        words = 1 << (off - 2);
        set   = (rq.address >> off) & ((1 << sb) - 1);
        tag   = 30'(rq.address >> (off + sb));
        base  = set * NWAYS;
        hit   = 1'b0;
        w     = 0;
        for (int i = 0; i < ways; i++)
        begin
            v  = inst ? i_vld[base+i] : d_vld[base+i];
            tg = inst ? i_tag[base+i] : d_tag[base+i];
            if (!hit && v && tg == tag)
            begin
                hit = 1'b1;
                w   = i;
            end
        end
        if (wr && !wbk)
            res.copy_back_words = 7'd1;
        if (hit)
        begin
            promote(inst, base, ways, w, 1'b0);
            if (wr && wbk && !inst)
                d_drt[base+w] = 1'b1;
        end
        else if (wr && !wal)
        begin
            if (wbk)
                res.copy_back_words = 7'd1;
        end
        else
        begin
            res.fetch_words = 7'(words);
            found = 1'b0;
            for (int i = 0; i < ways; i++)
            begin
                v = inst ? i_vld[base+i] : d_vld[base+i];
                if (!found && !v)
                begin
                    found = 1'b1;
                    w     = i;
                end
            end
            if (found)
                promote(inst, base, ways, w, 1'b1);
            else
            begin
                // victim: highest rank, lowest way on a tie
                w = 0;
                for (int i = 1; i < ways; i++)
                begin
                    if ((inst ? i_rank[base+i] : d_rank[base+i]) >
                        (inst ? i_rank[base+w] : d_rank[base+w]))
                        w = i;
                end
                res.replaced = 1'b1;
                if (!inst && d_drt[base+w])
                begin
                    res.dirty_evicted   = 1'b1;
                    res.copy_back_words = res.copy_back_words + 7'(words);
                end
                promote(inst, base, ways, w, 1'b0);
            end
            if (inst)
            begin
                i_tag[base+w] = tag;
                i_vld[base+w] = 1'b1;
            end
            else
            begin
                d_tag[base+w] = tag;
                d_vld[base+w] = 1'b1;
                d_drt[base+w] = wr && wbk;
            end
        end
        res.hit             = hit;
        res.used_inst_cache = inst;
    endtask

    // push one request, honouring full; push stays high until the caller drops it
    task automatic send_request(input req_t rq, input bit has_ref, input rsp_t ref_rsp);
        rsp_t pred;
        req  <= rq;
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_access(rq, pred);
        if (has_ref && pred !== ref_rsp)
        begin
            $display("%0t directed row disagrees: typed %h predicted %h", $time,
                     ref_rsp, pred);
            errors++;
        end
        expected_rsp.push_back(pred);
        @(negedge clk);
    endtask

    // wait until every expected result has drained, then let the back end settle
    task automatic drain_results;
        while (expected_rsp.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // write one register at the falling edge, held for one rising edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [3:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        sh_cfg[idx] = val;
        @(negedge clk);
    endtask

    task automatic write_all(input logic [3:0] s, input logic [3:0] wb,
                             input logic [3:0] wa, input logic [3:0] off,
                             input logic [3:0] ways, input logic [3:0] dsb,
                             input logic [3:0] isb);
        write_reg(REG_SPLIT, s);
        write_reg(REG_WB, wb);
        write_reg(REG_WA, wa);
        write_reg(REG_OFF_BITS, off);
        write_reg(REG_WAYS, ways);
        write_reg(REG_DSET_BITS, dsb);
        write_reg(REG_ISET_BITS, isb);
        cfg_we <= 1'b0;
    endtask

    // result side: stall on its own pattern, check each popped result
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_rsp.size() == 0)
            begin
                $display("%0t unexpected result %h", $time, rsp);
                errors++;
            end
            else
            begin
                if (rsp.hit !== expected_rsp[0].hit)
                begin
                    $display("%0t hit expected %b actual %b", $time,
                             expected_rsp[0].hit, rsp.hit);
                    errors++;
                end
                if (rsp.used_inst_cache !== expected_rsp[0].used_inst_cache)
                begin
                    $display("%0t used_inst_cache expected %b actual %b", $time,
                             expected_rsp[0].used_inst_cache, rsp.used_inst_cache);
                    errors++;
                end
                if (rsp.replaced !== expected_rsp[0].replaced)
                begin
                    $display("%0t replaced expected %b actual %b", $time,
                             expected_rsp[0].replaced, rsp.replaced);
                    errors++;
                end
                if (rsp.dirty_evicted !== expected_rsp[0].dirty_evicted)
                begin
                    $display("%0t dirty_evicted expected %b actual %b", $time,
                             expected_rsp[0].dirty_evicted, rsp.dirty_evicted);
                    errors++;
                end
                if (rsp.fetch_words !== expected_rsp[0].fetch_words)
                begin
                    $display("%0t fetch_words expected %0d actual %0d", $time,
                             expected_rsp[0].fetch_words, rsp.fetch_words);
                    errors++;
                end
                if (rsp.copy_back_words !== expected_rsp[0].copy_back_words)
                begin
                    $display("%0t copy_back_words expected %0d actual %0d", $time,
                             expected_rsp[0].copy_back_words, rsp.copy_back_words);
                    errors++;
                end
                void'(expected_rsp.pop_front());
            end
        end
    end

    // receiver stall pattern: free-flowing stretches, then random stalls
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if ((cycles / 512) % 3 == 0)
            pop <= 1'b1;
        else
            pop <= ($urandom_range(0, 3) != 0);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // directed table: address, mode, whether a result is typed, typed result
    typedef struct {
        logic [31:0] addr;
        logic [1:0]  mode;
        bit          typed;
        rsp_t        res;
    } row_t;

    row_t table_rows [$];

    function automatic rsp_t mk(input bit h, input bit ic, input bit rp, input bit de,
                                input int fw, input int cw);
        rsp_t r;
        r = '{h, ic, rp, de, 7'(fw), 7'(cw)};
        return r;
    endfunction

    task automatic add_row(input logic [31:0] a, input logic [1:0] m, input bit t,
                           input rsp_t r);
        row_t row;
        row = '{a, m, t, r};
        table_rows.push_back(row);
    endtask

    // random address from a small pool of tags so that hits and evictions occur
    function automatic logic [31:0] pick_address();
        logic [31:0] a;
        case ($urandom_range(0, 9))
            0:       a = $urandom();
            1:       a = 32'hFFFF_FFFF - $urandom_range(0, 255);
            default: a = (($urandom_range(0, 5) == 0 ? $urandom()
                           : 32'($urandom_range(0, 7))) << 20)
                         ^ (32'($urandom_range(0, 15)) << $urandom_range(2, 8))
                         ^ 32'($urandom_range(0, 3));
        endcase
        // flip every bit now and then so that high bits see both values
        if ($urandom_range(0, 7) == 0)
            a = ~a;
        return a;
    endfunction

    task automatic random_phase(input int n);
        req_t rq;
        int   burst;
        int   left;
        rsp_t none;
        none = '0;
        left = n;
        while (left > 0)
        begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && left > 0; k++)
            begin
                rq.address = pick_address();
                rq.mode    = $urandom_range(0, 15) == 0 ? MODE_NONE
                             : 2'($urandom_range(0, 2));
                send_request(rq, 1'b0, none);
                left--;
            end
            // gap between bursts, sometimes none at all
            if ($urandom_range(0, 2) != 0)
            begin
                push <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
        push <= 1'b0;
    endtask

    initial
    begin
        req_t rq;
        rsp_t none;
        none      = '0;
        rst_n     = 1'b0;
        push      = 1'b0;
        req       = '0;
        cfg_we    = 1'b0;
        cfg_idx   = '0;
        cfg_data  = '0;
        errors    = 0;
        cycles    = 0;
        sh_cfg[REG_SPLIT]     = 4'd0;
        sh_cfg[REG_WB]        = 4'd1;
        sh_cfg[REG_WA]        = 4'd1;
        sh_cfg[REG_OFF_BITS]  = 4'd4;
        sh_cfg[REG_WAYS]      = 4'd1;
        sh_cfg[REG_DSET_BITS] = 4'd6;
        sh_cfg[REG_ISET_BITS] = 4'd6;
        for (int i = 0; i < NLINES; i++)
        begin
            d_tag[i] = '0; d_vld[i] = 1'b0; d_drt[i] = 1'b0; d_rank[i] = 0;
            i_tag[i] = '0; i_vld[i] = 1'b0; i_rank[i] = 0;
        end
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // directed, reset settings: 16-byte blocks, direct mapped, 64 sets
        add_row(32'h0000_0000, MODE_READ,  1, mk(0, 0, 0, 0, 4, 0));
        add_row(32'h0000_0004, MODE_READ,  1, mk(1, 0, 0, 0, 0, 0));
        add_row(32'h0000_0008, MODE_WRITE, 1, mk(1, 0, 0, 0, 0, 0));
        // same set, other tag: evict the dirty line
        add_row(32'h0000_0400, MODE_READ,  1, mk(0, 0, 1, 1, 4, 4));
        add_row(32'hFFFF_FFFF, MODE_WRITE, 1, mk(0, 0, 0, 0, 4, 0));
        add_row(32'hFFFF_FFF0, MODE_FETCH, 1, mk(1, 0, 0, 0, 0, 0));
        add_row(32'hFFFF_FFF0, MODE_NONE,  1, mk(0, 0, 0, 0, 0, 0));
        add_row(32'h0000_0000, MODE_NONE,  1, mk(0, 0, 0, 0, 0, 0));
        add_row(32'h0000_0000, MODE_FETCH, 1, mk(0, 0, 1, 0, 4, 0));
        add_row(32'h8000_0404, MODE_READ,  0, none);
        add_row(32'h7FFF_FC04, MODE_WRITE, 0, none);
        foreach (table_rows[i])
        begin
            rq.address = table_rows[i].addr;
            rq.mode    = table_rows[i].mode;
            send_request(rq, table_rows[i].typed, table_rows[i].res);
        end
        push <= 1'b0;
        drain_results();

        // split, write-through, no allocate, out-of-range values saturate
        write_all(4'd1, 4'd0, 4'd0, 4'd15, 4'd15, 4'd15, 4'd0);
        table_rows.delete();
        add_row(32'h0000_1000, MODE_WRITE, 1, mk(0, 0, 0, 0, 0, 1));
        add_row(32'h0000_1000, MODE_FETCH, 1, mk(0, 1, 0, 0, 64, 0));
        add_row(32'h0000_1000, MODE_FETCH, 1, mk(1, 1, 0, 0, 0, 0));
        add_row(32'h0000_1000, MODE_READ,  1, mk(0, 0, 0, 0, 64, 0));
        add_row(32'h0000_1000, MODE_WRITE, 1, mk(1, 0, 0, 0, 0, 1));
        add_row(32'hFFFF_FFFF, MODE_FETCH, 0, none);
        add_row(32'h0001_2345, MODE_READ,  0, none);
        foreach (table_rows[i])
        begin
            rq.address = table_rows[i].addr;
            rq.mode    = table_rows[i].mode;
            send_request(rq, table_rows[i].typed, table_rows[i].res);
        end
        push <= 1'b0;
        drain_results();

        // write-back without allocation: a write miss copies one word
        write_all(4'd0, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd10);
        rq.address = 32'h0000_0100;
        rq.mode    = MODE_WRITE;
        send_request(rq, 1'b1, mk(0, 0, 0, 0, 0, 1));
        push <= 1'b0;
        drain_results();

        // random phases over several settings, extremes among them
        write_all(4'd0, 4'd1, 4'd1, 4'd2, 4'd4, 4'd2, 4'd2);
        random_phase(N_RANDOM / 6);
        drain_results();
        write_all(4'd1, 4'd1, 4'd1, 4'd4, 4'd8, 4'd1, 4'd3);
        random_phase(N_RANDOM / 6);
        drain_results();
        write_all(4'd1, 4'd0, 4'd1, 4'd8, 4'd2, 4'd0, 4'd10);
        random_phase(N_RANDOM / 6);
        drain_results();
        // grow associativity with state kept
        write_all(4'd0, 4'd1, 4'd0, 4'd3, 4'd3, 4'd10, 4'd0);
        random_phase(N_RANDOM / 6);
        drain_results();
        write_all(4'd1, 4'd0, 4'd0, 4'd5, 4'd1, 4'd3, 4'd1);
        random_phase(N_RANDOM / 6);
        drain_results();
        write_all(4'd0, 4'd1, 4'd1, 4'd1, 4'd7, 4'd1, 4'd6);
        random_phase(N_RANDOM / 6);

        // final wait for the last results, then settle
        drain_results();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire
